[rtl/core/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sample statistics block
// Opcodes, widths and store geometry.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int SENSOR_COUNT = 2;
    localparam int STORE_DEPTH  = 64;
    localparam int SAMPLE_BITS  = 16;

    localparam int ID_BITS   = 1;
    localparam int SLOT_BITS = $clog2(STORE_DEPTH);
    localparam int CNT_BITS  = 7;
    localparam int ADDR_BITS = ID_BITS + SLOT_BITS;
    localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS + 1;
    localparam int DIFF_BITS = SAMPLE_BITS + 2;
    localparam int SQ_BITS   = 2 * DIFF_BITS + SLOT_BITS;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

[rtl/core/sample_buffer_statistics.sv]
// ----------------------------------------------------------------------------
// sample_buffer_statistics: per-sensor sample store with mean/peak/std dev
//
// Usage: one input word (opcode, sensor_id, sample) is taken when in_valid
// is high and in_stall low. Each word yields exactly one result word on the
// output channel (out_valid / out_stall).
// Push, clear, an unused opcode and a report on an empty store post their
// result in the cycle after the word is taken.
// A report with n samples walks the store twice through one registered read
// port, divides |sum| by n in SUM_BITS restoring steps, divides the squared
// deviations by n-1 in SQ_BITS steps and takes a bit-pair square root in
// SQ_BITS/2 steps, all on one shared subtract/compare unit. A single sample
// skips the second divide and the root.
// The block takes no new word while one is in work or while a result waits
// stalled; it takes the next word in the same cycle the result is taken.
// Reset clears the sample counts (stores start empty); store contents need
// no reset since only slots below the count are read.
// If the receiver stalls, the result holds in the output register.
// ----------------------------------------------------------------------------
module sample_buffer_statistics
    import sbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic                   sensor_id,
    input  logic signed [15:0]     sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   status,
    output logic                   is_empty,
    output logic signed [15:0]     mean,
    output logic [15:0]            peak,
    output logic [15:0]            std_dev,
    output logic [6:0]             count
);

    typedef enum logic [2:0] {
        S_IDLE, S_PASS1, S_MDIV, S_PASS2, S_QDIV, S_SQRT, S_DONE
    } state_t;

    state_t state_reg;

    // store: one write port, one registered read port
    logic signed [SAMPLE_BITS-1:0] mem [0:SENSOR_COUNT*STORE_DEPTH-1];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic                          wr_en;
    logic [ADDR_BITS-1:0]          wr_addr;

    logic [CNT_BITS-1:0] cnt_reg [0:SENSOR_COUNT-1];

    logic                  id_reg;
    logic [CNT_BITS-1:0]   n_reg;
    logic [CNT_BITS-1:0]   idx_reg;     // read address issued
    logic                  rd_vld_reg;  // rd_data_reg holds a sample
    logic signed [SUM_BITS-1:0] sum_reg;
    logic [SAMPLE_BITS:0]  pk_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic signed [SAMPLE_BITS:0] m_reg;

    // shared divider / root datapath
    logic [SQ_BITS-1:0]    num_reg;     // dividend bits shifting out / root radicand
    logic [SQ_BITS:0]      rem_reg;
    logic [SQ_BITS-1:0]    quo_reg;
    logic [6:0]            step_reg;
    logic                  neg_reg;

    logic [CNT_BITS-1:0]   cur_cnt;
    assign cur_cnt = cnt_reg[sensor_id];

    assign in_stall = (state_reg != S_IDLE) || (out_valid && out_stall);

    logic accept;
    assign accept = in_valid && !in_stall;

    // a result word is posted now: any word but a non-empty report, or a finished report
    logic post_result;
    assign post_result = (accept && !((op_t'(opcode) == OP_REPORT) && (cur_cnt != '0)))
                         || (state_reg == S_DONE);

    // write path for push
    logic [CNT_BITS-1:0] push_slot;
    assign push_slot = (cur_cnt >= CNT_BITS'(STORE_DEPTH)) ? '0 : cur_cnt;
    assign wr_en   = accept && (op_t'(opcode) == OP_PUSH);
    assign wr_addr = {sensor_id, push_slot[SLOT_BITS-1:0]};
    assign rd_addr = {id_reg, idx_reg[SLOT_BITS-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= sample[SAMPLE_BITS-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared subtractor: divider step or root step
    logic [SQ_BITS:0] sub_a;
    logic [SQ_BITS:0] sub_b;
    logic [SQ_BITS+1:0] sub_r;
    logic               sub_ok;
    always_comb
    begin
        sub_a = {rem_reg[SQ_BITS-1:0], num_reg[SQ_BITS-1]};
        sub_b = {{(SQ_BITS+1-CNT_BITS){1'b0}}, n_reg};
        case (state_reg)
            S_MDIV:
            begin
                sub_b = {{(SQ_BITS+1-CNT_BITS){1'b0}}, n_reg};
            end
            S_QDIV:
            begin
                sub_b = {{(SQ_BITS+1-CNT_BITS){1'b0}}, n_reg - CNT_BITS'(1)};
            end
            S_SQRT:
            begin
                sub_a = {rem_reg[SQ_BITS-2:0], num_reg[SQ_BITS-1:SQ_BITS-2]};
                sub_b = {quo_reg[SQ_BITS-2:0], 2'b01};
            end
            default:
            begin
            end
        endcase
        sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ok = !sub_r[SQ_BITS+1];
    end

    // datapath helpers
    logic [SAMPLE_BITS:0] abs_x;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0] adiff;
    logic [2*DIFF_BITS-1:0] adiff_sq;
    assign abs_x = rd_data_reg[SAMPLE_BITS-1] ?
                   (SAMPLE_BITS+1)'(-$signed({rd_data_reg[SAMPLE_BITS-1], rd_data_reg}))
                   : {1'b0, rd_data_reg};
    assign diff  = DIFF_BITS'(rd_data_reg) - DIFF_BITS'(m_reg);
    assign adiff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : diff;
    assign adiff_sq = adiff * adiff;

    logic [SUM_BITS-1:0] abs_sum;
    assign abs_sum = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            for (int s = 0; s < SENSOR_COUNT; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            if (post_result)
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg   <= sensor_id;
                        status   <= 1'b0;
                        mean     <= '0;
                        peak     <= '0;
                        std_dev  <= '0;
                        case (op_t'(opcode))
                            OP_PUSH:
                            begin
                                cnt_reg[sensor_id] <= push_slot + CNT_BITS'(1);
                                count     <= push_slot + CNT_BITS'(1);
                                is_empty  <= 1'b0;
                            end
                            OP_CLEAR:
                            begin
                                cnt_reg[sensor_id] <= '0;
                                count     <= '0;
                                is_empty  <= 1'b1;
                            end
                            OP_REPORT:
                            begin
                                count    <= cur_cnt;
                                is_empty <= (cur_cnt == '0);
                                if (cur_cnt == '0)
                                begin
                                    status    <= 1'b1;
                                end
                                else
                                begin
                                    n_reg      <= cur_cnt;
                                    idx_reg    <= '0;
                                    rd_vld_reg <= 1'b0;
                                    sum_reg    <= '0;
                                    pk_reg     <= '0;
                                    state_reg  <= S_PASS1;
                                end
                            end
                            default:
                            begin
                                count     <= cur_cnt;
                                is_empty  <= (cur_cnt == '0);
                            end
                        endcase
                    end
                end
                S_PASS1:
                begin
                    if (rd_vld_reg)
                    begin
                        sum_reg <= sum_reg + SUM_BITS'(rd_data_reg);
                        if (abs_x > pk_reg)
                        begin
                            pk_reg <= abs_x;
                        end
                    end
                    if (idx_reg == n_reg)
                    begin
                        rd_vld_reg <= 1'b0;
                        state_reg  <= S_MDIV;
                        step_reg   <= '0;
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                    end
                    else
                    begin
                        idx_reg    <= idx_reg + CNT_BITS'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_MDIV:
                begin
                    if (step_reg == '0 && !rd_vld_reg)
                    begin
                        // load |sum| into the dividend
                        neg_reg    <= sum_reg[SUM_BITS-1];
                        num_reg    <= SQ_BITS'(abs_sum) << (SQ_BITS - SUM_BITS);
                        rd_vld_reg <= 1'b1;
                    end
                    else if (step_reg == 7'(SUM_BITS))
                    begin
                        m_reg <= neg_reg ? -$signed((SAMPLE_BITS+1)'(quo_reg))
                                         : $signed((SAMPLE_BITS+1)'(quo_reg));
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        sq_reg     <= '0;
                        state_reg  <= S_PASS2;
                    end
                    else
                    begin
                        rem_reg  <= sub_ok ? sub_r[SQ_BITS:0] : sub_a;
                        quo_reg  <= {quo_reg[SQ_BITS-2:0], sub_ok};
                        num_reg  <= num_reg << 1;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_PASS2:
                begin
                    if (rd_vld_reg)
                    begin
                        sq_reg <= sq_reg + SQ_BITS'(adiff_sq);
                    end
                    if (idx_reg == n_reg)
                    begin
                        rd_vld_reg <= 1'b0;
                        step_reg   <= '0;
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                        state_reg  <= (n_reg == CNT_BITS'(1)) ? S_DONE : S_QDIV;
                    end
                    else
                    begin
                        idx_reg    <= idx_reg + CNT_BITS'(1);
                        rd_vld_reg <= 1'b1;
                    end
                end
                S_QDIV:
                begin
                    if (step_reg == '0 && !rd_vld_reg)
                    begin
                        num_reg    <= sq_reg;
                        rd_vld_reg <= 1'b1;
                    end
                    else if (step_reg == 7'(SQ_BITS))
                    begin
                        num_reg   <= quo_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        rem_reg  <= sub_ok ? sub_r[SQ_BITS:0] : sub_a;
                        quo_reg  <= {quo_reg[SQ_BITS-2:0], sub_ok};
                        num_reg  <= num_reg << 1;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_SQRT:
                begin
                    // bit-pair restoring root; quo_reg builds the root
                    if (step_reg == 7'(SQ_BITS / 2))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rem_reg  <= sub_ok ? sub_r[SQ_BITS:0] : sub_a;
                        quo_reg  <= {quo_reg[SQ_BITS-2:0], sub_ok};
                        num_reg  <= num_reg << 2;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_DONE:
                begin
                    mean      <= m_reg[SAMPLE_BITS-1:0];
                    peak      <= pk_reg[SAMPLE_BITS-1:0];
                    std_dev   <= (quo_reg > SQ_BITS'({SAMPLE_BITS{1'b1}})) ?
                                 {SAMPLE_BITS{1'b1}} : quo_reg[SAMPLE_BITS-1:0];
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // assertions
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CNT_BITS'(STORE_DEPTH)) && (cnt_reg[1] <= CNT_BITS'(STORE_DEPTH)))
        else $error("count beyond store depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(std_dev) && $stable(count))
        else $error("stalled result changed");

    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid && (state_reg == S_IDLE))
        else $error("report result not posted");

endmodule

[tb/sample_buffer_statistics_tb.sv]
// ----------------------------------------------------------------------------
// sample_buffer_statistics_tb: self-checking bench for the sample statistics
// Drives push/clear/report and unused-op words through a directed table and
// four random phases, predicts every result word with an integer model of
// the store, and compares each output word field by field in arrival order.
// ----------------------------------------------------------------------------
module sample_buffer_statistics_tb;
    import sbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DIRECTED_ROWS  = 22;

    typedef struct packed {
        logic        status;
        logic        is_empty;
        logic [15:0] mean;
        logic [15:0] peak;
        logic [15:0] std_dev;
        logic [6:0]  count;
    } stats_t;

    // directed row: word to send, plus an optional typed-in result
    typedef struct {
        op_t         op;
        logic        id;
        logic [15:0] smp;
        bit          fixed;
        stats_t      res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = OP_PUSH;
    logic sensor_id = 1'b0;
    logic signed [15:0] sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic status, is_empty;
    logic signed [15:0] mean;
    logic [15:0] peak, std_dev;
    logic [6:0] count;

    // predictor state: per-sensor sample store and fill count
    logic signed [15:0] store_mem [SENSOR_COUNT][STORE_DEPTH];
    int                 store_fill [SENSOR_COUNT];

    stats_t pending_stats[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    row_t   rows [DIRECTED_ROWS];

    sample_buffer_statistics dut (.*);

    always #2 clk = ~clk;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // applies one word to the model store and returns the expected result
    function automatic stats_t apply_word(op_t op, logic id, logic signed [15:0] smp);
        stats_t r;
        longint sum, m, d;
        longint unsigned pk, sq, q, a;
        int n;
        r = '0;
        if (op == OP_PUSH) begin
            if (store_fill[id] >= STORE_DEPTH) store_fill[id] = 0;
            store_mem[id][store_fill[id]] = smp;
            store_fill[id]++;
        end else if (op == OP_CLEAR) begin
            store_fill[id] = 0;
        end else if (op == OP_REPORT) begin
            n = store_fill[id];
            if (n == 0) begin
                r.status = 1'b1;
            end else begin
                sum = 0;
                pk = 0;
                sq = 0;
                for (int i = 0; i < n; i++) begin
                    sum += store_mem[id][i];
                    a = (store_mem[id][i] < 0) ? -longint'(store_mem[id][i])
                                               : store_mem[id][i];
                    if (a > pk) pk = a;
                end
                m = sum / n;
                for (int i = 0; i < n; i++) begin
                    d = longint'(store_mem[id][i]) - m;
                    a = (d < 0) ? -d : d;
                    sq += a * a;
                end
                q = (n > 1) ? isqrt(sq / (n - 1)) : 0;
                if (q > 64'hFFFF) q = 64'hFFFF;
                r.mean = m[15:0];
                r.peak = pk[15:0];
                r.std_dev = q[15:0];
            end
        end
        r.count = store_fill[id][6:0];
        r.is_empty = (store_fill[id] == 0);
        return r;
    endfunction

    // sends one word, holding it until accepted; random gaps ahead of it
    task automatic send_word(op_t op, logic id, logic [15:0] smp, bit fixed, stats_t res);
        stats_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        sensor_id <= id;
        sample <= smp;
        e = apply_word(op, id, smp);
        if (fixed && e != res) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with model: op %0d id %0d want %h model %h",
                    op, id, res, e);
        end
        pending_stats.push_back(e);
        @(posedge clk);
        while (!(in_valid && !in_stall)) @(posedge clk);
    endtask

    // random operand biased toward extremes
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // drops the input and waits for every expected word
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
    endtask

    // receiver stall generator
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // output checker
    always @(posedge clk) begin
        stats_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{status, is_empty, mean, peak, std_dev, count};
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = pending_stats.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %b/%b emp %b/%b mean %0d/%0d pk %0d/%0d sd %0d/%0d cnt %0d/%0d",
                            want.status, got.status, want.is_empty, got.is_empty,
                            $signed(want.mean), $signed(got.mean), want.peak, got.peak,
                            want.std_dev, got.std_dev, want.count, got.count);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** sample_buffer_statistics: FAILED **");
            $finish;
        end
    end

    initial begin
        op_t op;
        logic id;
        stats_t z;
        z = '0;
        for (int s = 0; s < SENSOR_COUNT; s++) store_fill[s] = 0;

        // report empty, single sample, extremes, clear, unused op
        rows[0]  = '{OP_REPORT, 1'b0, 16'h0000, 1, '{1, 1, 0, 0, 0, 0}};
        rows[1]  = '{OP_PUSH,   1'b0, 16'h8000, 1, '{0, 0, 0, 0, 0, 1}};
        rows[2]  = '{OP_REPORT, 1'b0, 16'h0000, 1, '{0, 0, 16'h8000, 16'h8000, 0, 1}};
        rows[3]  = '{OP_PUSH,   1'b0, 16'h7FFF, 0, z};
        rows[4]  = '{OP_REPORT, 1'b0, 16'h0000, 0, z};
        rows[5]  = '{OP_NONE,   1'b0, 16'hFFFF, 1, '{0, 0, 0, 0, 0, 2}};
        rows[6]  = '{OP_PUSH,   1'b1, 16'h7FFF, 1, '{0, 0, 0, 0, 0, 1}};
        rows[7]  = '{OP_REPORT, 1'b1, 16'h0000, 1, '{0, 0, 16'h7FFF, 16'h7FFF, 0, 1}};
        rows[8]  = '{OP_PUSH,   1'b1, 16'hFFFF, 0, z};
        rows[9]  = '{OP_PUSH,   1'b1, 16'h0001, 0, z};
        rows[10] = '{OP_REPORT, 1'b1, 16'h0000, 0, z};
        rows[11] = '{OP_CLEAR,  1'b1, 16'h1234, 1, '{0, 1, 0, 0, 0, 0}};
        rows[12] = '{OP_REPORT, 1'b1, 16'h0000, 1, '{1, 1, 0, 0, 0, 0}};
        rows[13] = '{OP_NONE,   1'b1, 16'h0000, 1, '{0, 1, 0, 0, 0, 0}};
        rows[14] = '{OP_CLEAR,  1'b0, 16'h0000, 1, '{0, 1, 0, 0, 0, 0}};
        for (int i = 15; i < DIRECTED_ROWS; i++)
            rows[i] = '{OP_PUSH, 1'b0, (i[0] ? 16'h8000 : 16'h7FFF), 0, z};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) send_word(rows[i].op, rows[i].id, rows[i].smp, rows[i].fixed, rows[i].res);

        // push a full store of alternating extremes into sensor 0, so it fills and wraps
        for (int i = 0; i < STORE_DEPTH; i++)
            send_word(OP_PUSH, 1'b0, (i[0] ? 16'h8000 : 16'h7FFF), 0, z);
        send_word(OP_REPORT, 1'b0, 16'h0, 0, z);
        send_word(OP_PUSH, 1'b0, 16'h0005, 0, z);
        send_word(OP_REPORT, 1'b0, 16'h0, 0, z);

        // pause the sender until everything has drained
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 53 : (ph == 3) ? 33 : 0;
            stall_pct     = (ph == 2) ? 53 : (ph == 3) ? 33 : 0;
            for (int k = 0; k < 300; k++) begin
                id = 1'($urandom_range(1));
                case ($urandom_range(19))
                    0:               op = OP_CLEAR;
                    1:               op = OP_NONE;
                    2, 3, 4, 5:      op = OP_REPORT;
                    default:         op = OP_PUSH;
                endcase
                send_word(op, id, rand_sample(), 0, z);
            end
            wait_drained();
        end

        stall_pct = 0;
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("** sample_buffer_statistics: PASSED **");
        else
            $display("** sample_buffer_statistics: FAILED **");
        $finish;
    end

endmodule
